// ----- rtl/core/fsp_pkg.sv -----
`default_nettype none

package fsp_pkg;

  // Field widths
  localparam int unsigned TICK_W    = 32;
  localparam int unsigned FREQ_W    = 32;
  localparam int unsigned PHASE_W   = 32;
  localparam int unsigned ELAPSED_W = 31;
  localparam int unsigned RATE_W    = 10;
  localparam int unsigned STEPS_W   = 8;
  localparam int unsigned ALPHA_W   = 16;

  // elapsed * rate, then phase + product (one carry bit)
  localparam int unsigned PROD_W    = ELAPSED_W + RATE_W;
  localparam int unsigned TOTAL_W   = PROD_W + 1;
  localparam int unsigned DIV_CNT_W = $clog2(TOTAL_W + 1);

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_TICK_RATE       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP_LIMIT       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SHOW_MODE       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SIMULATION_RATE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_RATE      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_CAP        = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_START_TICK      = 3'd6;

  // Register reset values
  localparam logic [FREQ_W-1:0]    TICK_RATE_RESET       = 32'd1000;
  localparam logic [ELAPSED_W-1:0] GAP_LIMIT_RESET       = 31'd250;
  localparam logic                 SHOW_MODE_RESET       = 1'b0;
  localparam logic [RATE_W-1:0]    SIMULATION_RATE_RESET = 10'd35;
  localparam logic [RATE_W-1:0]    FRAME_RATE_RESET      = 10'd60;
  localparam logic [STEPS_W-1:0]   STEP_CAP_RESET        = 8'd8;
  localparam logic [TICK_W-1:0]    START_TICK_RESET      = 32'd0;

  localparam logic [RATE_W-1:0] RATE_MAX = 10'd1000;

  localparam int unsigned MIN_CLOCK_HZ_DEFAULT = 1000;

  // Present mode codes
  localparam logic MODE_NORMAL = 1'b0;
  localparam logic MODE_LEGACY = 1'b1;

  // Item kind codes
  localparam logic KIND_ADVANCE       = 1'b0;
  localparam logic KIND_ADVANCE_PAUSE = 1'b1;

  // Status codes
  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_CFG_ERROR = 1'b1;

  typedef struct packed {
    logic [FREQ_W-1:0]    tick_rate;
    logic [ELAPSED_W-1:0] gap_limit;
    logic                 show_mode;
    logic [RATE_W-1:0]    simulation_rate;
    logic [RATE_W-1:0]    frame_rate;
    logic [STEPS_W-1:0]   step_cap;
  } cfg_t;

  typedef struct packed {
    logic                 start;
    logic [PHASE_W-1:0]   rem_init;
    logic [TOTAL_W-1:0]   num;
    logic [DIV_CNT_W-1:0] iters;
    logic [FREQ_W-1:0]    den;
  } div_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic [TOTAL_W-1:0] quo;
    logic [PHASE_W-1:0] rem;
  } div_rsp_t;

endpackage

`default_nettype wire

// ----- rtl/core/fsp_item_if.sv -----
`default_nettype none

interface fsp_item_if import fsp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              kind;
  logic [TICK_W-1:0] now_tick;
  logic              pause_request;

  modport source (output valid, output kind, output now_tick, output pause_request,
                  input ready);
  modport sink   (input valid, input kind, input now_tick, input pause_request,
                  output ready);
endinterface

`default_nettype wire

// ----- rtl/core/fsp_result_if.sv -----
`default_nettype none

interface fsp_result_if import fsp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               status;
  logic [STEPS_W-1:0] step_count;
  logic [STEPS_W-1:0] simulation_ticks;
  logic               present;
  logic               gap_limited;
  logic               step_limited;
  logic [ALPHA_W-1:0] interp_frac;

  modport source (output valid, output status, output step_count, output simulation_ticks,
                  output present, output gap_limited, output step_limited,
                  output interp_frac, input ready);
  modport sink   (input valid, input status, input step_count, input simulation_ticks,
                  input present, input gap_limited, input step_limited,
                  input interp_frac, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/fixed_step_frame_pacer_core.sv -----
// Fixed-step frame pacer.
// Item channel (item): one transaction per frame carries the current free-running
// tick stamp, a kind bit (advance, or advance then set the pause state) and the
// pause request. Result channel (result): one transaction per item with status,
// fixed and simulation step counts, present flag, clamp flags and the Q16 alpha.
// Configuration is a write-only port (cfg_we, cfg_index, cfg_wdata), one register
// per write; write it only while no item is in flight.
// Each item walks a small sequencer around one shared 42-bit restoring divider,
// one quotient bit per cycle: the simulation divide and the presentation divide
// take 42 - floor(log2(MIN_CLOCK_HZ)) steps each (33 at the default), the alpha
// divide 16. An accepted item runs check, then the simulation and presentation divides
// and, in normal mode only, the alpha divide; an invalid configuration goes from
// check straight to finish. item.ready rises in the same cycle as result.valid.
// A finished result sits in an output register; the next item is accepted while
// it waits. If the receiver still holds off when the following result is ready,
// the sequencer holds it until the output register frees up.
// Reset (rst, synchronous) restores the configuration, loads the previous tick with the
// start tick reset value, clears the phases and the pause flag, and drops result.valid.
`default_nettype none

module fixed_step_frame_pacer_core import fsp_pkg::*; #(
  parameter int unsigned MIN_CLOCK_HZ = MIN_CLOCK_HZ_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  fsp_item_if.sink              item,
  fsp_result_if.source          result
);

  // Top dividend bits that are always below any legal frequency
  localparam int unsigned PRELOAD_W = $clog2(MIN_CLOCK_HZ + 1) - 1;
  localparam int unsigned SIM_ITERS = TOTAL_W - PRELOAD_W;

  typedef enum logic [10:0] {
    ST_IDLE        = 11'b000_0000_0001,
    ST_CHECK       = 11'b000_0000_0010,
    ST_SIM_MUL     = 11'b000_0000_0100,
    ST_SIM_START   = 11'b000_0000_1000,
    ST_SIM_WAIT    = 11'b000_0001_0000,
    ST_PRES_MUL    = 11'b000_0010_0000,
    ST_PRES_START  = 11'b000_0100_0000,
    ST_PRES_WAIT   = 11'b000_1000_0000,
    ST_ALPHA_START = 11'b001_0000_0000,
    ST_ALPHA_WAIT  = 11'b010_0000_0000,
    ST_FINISH      = 11'b100_0000_0000
  } state_t;

  cfg_t     cfg;
  div_req_t div_req;
  div_rsp_t div_rsp;

  state_t state;

  logic [TICK_W-1:0]  prev_tick;
  logic [PHASE_W-1:0] sim_phase;
  logic [PHASE_W-1:0] paused_phase;
  logic [PHASE_W-1:0] pres_phase;
  logic               paused_flag;

  logic               cur_kind;
  logic [TICK_W-1:0]  cur_tick;
  logic               cur_pause_request;

  logic               err;
  logic [ELAPSED_W-1:0] elapsed;
  logic               gap_hit;
  logic [PROD_W-1:0]  prod;
  logic [STEPS_W-1:0] sched;
  logic               cap_hit;
  logic [STEPS_W-1:0] sim_ticks;
  logic               present;
  logic [ALPHA_W-1:0] alpha;

  logic               out_valid;
  logic               out_status;
  logic [STEPS_W-1:0] out_step_count;
  logic [STEPS_W-1:0] out_simulation_ticks;
  logic               out_present;
  logic               out_gap_limited;
  logic               out_step_limited;
  logic [ALPHA_W-1:0] out_alpha;

  logic               cfg_ok;
  logic [TICK_W-1:0]  tick_diff;
  logic               over_max;
  logic [RATE_W-1:0]  mul_rate;
  logic [PHASE_W-1:0] phase_sel;
  logic [TOTAL_W-1:0] div_total;
  logic               over_catchup;
  logic               out_free;

  fsp_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  fsp_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_comb begin
    cfg_ok = (cfg.tick_rate >= FREQ_W'(MIN_CLOCK_HZ))
          && (cfg.gap_limit != '0)
          && (cfg.simulation_rate != '0) && (cfg.simulation_rate <= RATE_MAX)
          && (cfg.frame_rate != '0) && (cfg.frame_rate <= RATE_MAX)
          && (cfg.step_cap != '0)
          && (sim_phase < cfg.tick_rate)
          && (paused_phase < cfg.tick_rate)
          && (pres_phase < cfg.tick_rate);

    tick_diff = cur_tick - prev_tick;
    over_max  = tick_diff > {1'b0, cfg.gap_limit};

    // Legacy mode presents at the simulation rate
    mul_rate = (state == ST_SIM_MUL || cfg.show_mode == MODE_LEGACY)
             ? cfg.simulation_rate : cfg.frame_rate;

    if (state == ST_PRES_START) begin
      phase_sel = pres_phase;
    end else if (paused_flag) begin
      phase_sel = paused_phase;
    end else begin
      phase_sel = sim_phase;
    end
    div_total = TOTAL_W'(phase_sel) + TOTAL_W'(prod);

    div_req.start = (state == ST_SIM_START) || (state == ST_PRES_START)
                 || (state == ST_ALPHA_START);
    div_req.den   = cfg.tick_rate;
    if (state == ST_ALPHA_START) begin
      div_req.rem_init = sim_phase;
      div_req.num      = '0;
      div_req.iters    = DIV_CNT_W'(ALPHA_W);
    end else begin
      div_req.rem_init = PHASE_W'(div_total >> (TOTAL_W - PRELOAD_W));
      div_req.num      = div_total << PRELOAD_W;
      div_req.iters    = DIV_CNT_W'(SIM_ITERS);
    end

    over_catchup = div_rsp.quo > TOTAL_W'(cfg.step_cap);
    out_free     = !out_valid || result.ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      prev_tick    <= START_TICK_RESET;
      sim_phase    <= '0;
      paused_phase <= '0;
      pres_phase   <= '0;
      paused_flag  <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (state == ST_FINISH && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && result.ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (item.valid) begin
            cur_kind          <= item.kind;
            cur_tick          <= item.now_tick;
            cur_pause_request <= item.pause_request;
            state             <= ST_CHECK;
          end
        end

        ST_CHECK: begin
          err <= !cfg_ok;
          if (cfg_ok) begin
            prev_tick <= cur_tick;
            elapsed   <= over_max ? cfg.gap_limit : tick_diff[ELAPSED_W-1:0];
            gap_hit   <= over_max;
            state     <= ST_SIM_MUL;
          end else begin
            state <= ST_FINISH;
          end
        end

        ST_SIM_MUL: begin
          prod  <= PROD_W'(elapsed) * PROD_W'(mul_rate);
          state <= ST_SIM_START;
        end

        ST_SIM_START: begin
          state <= ST_SIM_WAIT;
        end

        ST_SIM_WAIT: begin
          if (div_rsp.done) begin
            // While paused only the paused phase moves
            paused_phase <= div_rsp.rem;
            if (!paused_flag) begin
              sim_phase <= div_rsp.rem;
            end
            sched     <= over_catchup ? cfg.step_cap : div_rsp.quo[STEPS_W-1:0];
            sim_ticks <= paused_flag ? '0
                       : (over_catchup ? cfg.step_cap : div_rsp.quo[STEPS_W-1:0]);
            cap_hit   <= over_catchup;
            state     <= ST_PRES_MUL;
          end
        end

        ST_PRES_MUL: begin
          prod  <= PROD_W'(elapsed) * PROD_W'(mul_rate);
          state <= ST_PRES_START;
        end

        ST_PRES_START: begin
          state <= ST_PRES_WAIT;
        end

        ST_PRES_WAIT: begin
          if (div_rsp.done) begin
            pres_phase <= div_rsp.rem;
            present    <= div_rsp.quo != '0;
            if (cfg.show_mode == MODE_LEGACY) begin
              alpha <= '0;
              state <= ST_FINISH;
            end else begin
              state <= ST_ALPHA_START;
            end
          end
        end

        ST_ALPHA_START: begin
          state <= ST_ALPHA_WAIT;
        end

        ST_ALPHA_WAIT: begin
          if (div_rsp.done) begin
            alpha <= div_rsp.quo[ALPHA_W-1:0];
            state <= ST_FINISH;
          end
        end

        ST_FINISH: begin
          // Hold until the output register is free
          if (out_free) begin
            if (err) begin
              out_status           <= STATUS_CFG_ERROR;
              out_step_count       <= '0;
              out_simulation_ticks <= '0;
              out_present          <= 1'b0;
              out_gap_limited      <= 1'b0;
              out_step_limited     <= 1'b0;
              out_alpha            <= '0;
            end else begin
              out_status           <= STATUS_OK;
              out_step_count       <= sched;
              out_simulation_ticks <= sim_ticks;
              out_present          <= present;
              out_gap_limited      <= gap_hit;
              out_step_limited     <= cap_hit;
              out_alpha            <= alpha;
              if (cur_kind == KIND_ADVANCE_PAUSE) begin
                // Entering pause: paused phase starts from the simulation phase
                if (cur_pause_request && !paused_flag) begin
                  paused_phase <= sim_phase;
                end
                paused_flag <= cur_pause_request;
              end
            end
            state <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign item.ready = (state == ST_IDLE);

  assign result.valid            = out_valid;
  assign result.status           = out_status;
  assign result.step_count       = out_step_count;
  assign result.simulation_ticks = out_simulation_ticks;
  assign result.present          = out_present;
  assign result.gap_limited      = out_gap_limited;
  assign result.step_limited     = out_step_limited;
  assign result.interp_frac      = out_alpha;

  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_error_result_zero: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.status == STATUS_CFG_ERROR) |->
      (result.step_count == '0 && result.simulation_ticks == '0 && !result.present
       && !result.gap_limited && !result.step_limited && result.interp_frac == '0))
    else $error("error result carries nonzero fields");

  a_sim_ticks_match: assert property (@(posedge clk) disable iff (rst)
    result.valid |->
      (result.simulation_ticks == '0 || result.simulation_ticks == result.step_count))
    else $error("simulation ticks differ from fixed ticks");

  a_catchup_at_limit: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.step_limited) |-> result.step_count == cfg.step_cap)
    else $error("catch-up clamp without fixed ticks at the limit");

endmodule

`default_nettype wire

// ----- rtl/core/fsp_cfg.sv -----
`default_nettype none

module fsp_cfg import fsp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.tick_rate       <= TICK_RATE_RESET;
      regs.gap_limit       <= GAP_LIMIT_RESET;
      regs.show_mode       <= SHOW_MODE_RESET;
      regs.simulation_rate <= SIMULATION_RATE_RESET;
      regs.frame_rate      <= FRAME_RATE_RESET;
      regs.step_cap        <= STEP_CAP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TICK_RATE:       regs.tick_rate       <= cfg_wdata[FREQ_W-1:0];
        CFG_GAP_LIMIT:       regs.gap_limit       <= cfg_wdata[ELAPSED_W-1:0];
        CFG_SHOW_MODE:       regs.show_mode       <= cfg_wdata[0];
        CFG_SIMULATION_RATE: regs.simulation_rate <= cfg_wdata[RATE_W-1:0];
        CFG_FRAME_RATE:      regs.frame_rate      <= cfg_wdata[RATE_W-1:0];
        CFG_STEP_CAP:        regs.step_cap        <= cfg_wdata[STEPS_W-1:0];
        // Start tick only seeds the previous tick at reset, and reset also restores it:
        // keep no copy.
        CFG_START_TICK:      ;
        default:             ;
      endcase
    end
  end

  assign cfg = regs;

endmodule

`default_nettype wire

// ----- rtl/core/fsp_div.sv -----
`default_nettype none

module fsp_div import fsp_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [PHASE_W-1:0]   rem;
  logic [TOTAL_W-1:0]   num;
  logic [TOTAL_W-1:0]   quo;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic                 done;

  logic [PHASE_W:0]   trial;
  logic [PHASE_W+1:0] diff;
  logic               fits;
  logic [PHASE_W-1:0] rem_next;

  // One restoring step: bring down the next dividend bit, subtract if it fits
  always_comb begin
    trial    = {rem, num[TOTAL_W-1]};
    diff     = {1'b0, trial} - {2'b00, req.den};
    fits     = !diff[PHASE_W+1];
    rem_next = fits ? diff[PHASE_W-1:0] : trial[PHASE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == DIV_CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= req.rem_init;
      num <= req.num;
      quo <= '0;
      cnt <= req.iters;
    end else if (busy) begin
      rem <= rem_next;
      num <= {num[TOTAL_W-2:0], 1'b0};
      quo <= {quo[TOTAL_W-2:0], fits};
      cnt <= cnt - DIV_CNT_W'(1);
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quo  = quo;
  assign rsp.rem  = rem;

endmodule

`default_nettype wire

// ----- tb/sv/fixed_step_frame_pacer_checker.sv -----
`timescale 1ns / 1ps

module fixed_step_frame_pacer_checker import fsp_pkg::*; #(
  parameter int unsigned MIN_CLOCK_HZ = MIN_CLOCK_HZ_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  fsp_item_if                   item_mon,
  fsp_result_if                 result_mon,
  output int                    errors,
  output int                    pending,
  output int                    results_seen,
  output int                    cfg_err_steps,
  output logic [PHASE_W-1:0]    phase_peak
);

  typedef struct packed {
    logic               status;
    logic [STEPS_W-1:0] step_count;
    logic [STEPS_W-1:0] simulation_ticks;
    logic               present;
    logic               gap_limited;
    logic               step_limited;
    logic [ALPHA_W-1:0] interp_frac;
  } frame_result_t;

  // register mirror
  logic [FREQ_W-1:0]    freq_r;
  logic [ELAPSED_W-1:0] max_el_r;
  logic                 mode_r;
  logic [RATE_W-1:0]    sim_rate_r;
  logic [RATE_W-1:0]    pres_rate_r;
  logic [STEPS_W-1:0]   max_fix_r;

  // pacer state mirror
  logic [TICK_W-1:0]  prev_tick_m;
  logic [PHASE_W-1:0] sim_ph;
  logic [PHASE_W-1:0] pau_ph;
  logic [PHASE_W-1:0] pres_ph;
  logic               paused_m;

  frame_result_t due_results[$];

  always_comb begin
    phase_peak = sim_ph;
    if (pau_ph > phase_peak) phase_peak = pau_ph;
    if (pres_ph > phase_peak) phase_peak = pres_ph;
  end

  function automatic logic setup_ok();
    if (freq_r < MIN_CLOCK_HZ) return 1'b0;
    if (max_el_r == '0 || max_fix_r == '0) return 1'b0;
    if (sim_rate_r == '0 || sim_rate_r > RATE_MAX) return 1'b0;
    if (pres_rate_r == '0 || pres_rate_r > RATE_MAX) return 1'b0;
    // phases left at or above a lowered frequency lock the block in error
    if (sim_ph >= freq_r || pau_ph >= freq_r || pres_ph >= freq_r) return 1'b0;
    return 1'b1;
  endfunction

  function automatic frame_result_t advance_pacer(input logic k, input logic [TICK_W-1:0] now,
                                                  input logic req);
    frame_result_t res;
    logic [TICK_W-1:0] elapsed;
    logic [63:0]       total;
    logic [63:0]       due;
    logic [63:0]       freq64;
    logic [RATE_W-1:0] pres_rate;
    res = '0;
    if (!setup_ok()) begin
      res.status = STATUS_CFG_ERROR;
      return res;
    end
    freq64 = {32'd0, freq_r};
    elapsed = now - prev_tick_m;
    prev_tick_m = now;
    if (elapsed > {1'b0, max_el_r}) begin
      elapsed = {1'b0, max_el_r};
      res.gap_limited = 1'b1;
    end

    total = {32'd0, (paused_m ? pau_ph : sim_ph)} + {32'd0, elapsed} * {54'd0, sim_rate_r};
    due = total / freq64;
    if (paused_m) begin
      pau_ph = 32'(total % freq64);
    end else begin
      sim_ph = 32'(total % freq64);
      pau_ph = sim_ph;
    end
    if (due > {56'd0, max_fix_r}) begin
      res.step_count = max_fix_r;
      res.step_limited = 1'b1;
    end else begin
      res.step_count = due[STEPS_W-1:0];
    end
    res.simulation_ticks = paused_m ? '0 : res.step_count;

    pres_rate = (mode_r == MODE_LEGACY) ? sim_rate_r : pres_rate_r;
    total = {32'd0, pres_ph} + {32'd0, elapsed} * {54'd0, pres_rate};
    due = total / freq64;
    pres_ph = 32'(total % freq64);
    res.present = (due != 0);

    if (mode_r == MODE_NORMAL) res.interp_frac = 16'(({32'd0, sim_ph} << 16) / freq64);

    // pause entry snapshots the simulation phase after the advance
    if (k == KIND_ADVANCE_PAUSE) begin
      if (req && !paused_m) pau_ph = sim_ph;
      paused_m = req;
    end
    res.status = STATUS_OK;
    return res;
  endfunction

  always @(posedge clk) begin
    frame_result_t want;
    frame_result_t got;
    if (rst) begin
      freq_r      = TICK_RATE_RESET;
      max_el_r    = GAP_LIMIT_RESET;
      mode_r      = SHOW_MODE_RESET;
      sim_rate_r  = SIMULATION_RATE_RESET;
      pres_rate_r = FRAME_RATE_RESET;
      max_fix_r   = STEP_CAP_RESET;
      prev_tick_m = START_TICK_RESET;
      sim_ph      = '0;
      pau_ph      = '0;
      pres_ph     = '0;
      paused_m    = 1'b0;
      due_results.delete();
      errors        = 0;
      results_seen  = 0;
      cfg_err_steps = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_TICK_RATE:       freq_r = cfg_wdata[FREQ_W-1:0];
          CFG_GAP_LIMIT:       max_el_r = cfg_wdata[ELAPSED_W-1:0];
          CFG_SHOW_MODE:       mode_r = cfg_wdata[0];
          CFG_SIMULATION_RATE: sim_rate_r = cfg_wdata[RATE_W-1:0];
          CFG_FRAME_RATE:      pres_rate_r = cfg_wdata[RATE_W-1:0];
          CFG_STEP_CAP:        max_fix_r = cfg_wdata[STEPS_W-1:0];
          // start tick only matters at reset, which restores it anyway
          CFG_START_TICK:      ;
          default: ;
        endcase
      end

      // retire before predicting so a stray result never pairs with a fresh item
      if (result_mon.valid && result_mon.ready) begin
        got.status           = result_mon.status;
        got.step_count       = result_mon.step_count;
        got.simulation_ticks = result_mon.simulation_ticks;
        got.present          = result_mon.present;
        got.gap_limited      = result_mon.gap_limited;
        got.step_limited     = result_mon.step_limited;
        got.interp_frac      = result_mon.interp_frac;
        results_seen++;
        if (got.status == STATUS_CFG_ERROR) cfg_err_steps++;
        if (due_results.size() == 0) begin
          errors++;
          $display("%0t unexpected result transaction: status=%0d fixed=%0d sim=%0d",
                   $time, got.status, got.step_count, got.simulation_ticks);
        end else begin
          want = due_results.pop_front();
          if (got !== want) begin
            errors++;
            $display("%0t result %0d expected: status=%0d fixed=%0d sim=%0d present=%0d",
                     $time, results_seen, want.status, want.step_count,
                     want.simulation_ticks, want.present);
            $display("    eclamp=%0d cclamp=%0d alpha=%0d", want.gap_limited,
                     want.step_limited, want.interp_frac);
            $display("  actual: status=%0d fixed=%0d sim=%0d present=%0d", got.status,
                     got.step_count, got.simulation_ticks, got.present);
            $display("    eclamp=%0d cclamp=%0d alpha=%0d", got.gap_limited,
                     got.step_limited, got.interp_frac);
          end
        end
      end

      if (item_mon.valid && item_mon.ready)
        due_results.push_back(advance_pacer(item_mon.kind, item_mon.now_tick,
                                            item_mon.pause_request));
    end
    pending <= due_results.size();
  end

endmodule

// ----- tb/sv/fixed_step_frame_pacer_core_tb.sv -----
`timescale 1ns / 1ps

module fixed_step_frame_pacer_core_tb import fsp_pkg::*; ();

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  typedef struct {
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
  } reg_write_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int                    errors;
  int                    pending;
  int                    results_seen;
  int                    cfg_err_steps;
  logic [PHASE_W-1:0]    phase_peak;

  bit                    idle = 1'b1;
  logic [TICK_W-1:0]     stamp = '0;
  logic [ELAPSED_W-1:0]  cur_max_el = GAP_LIMIT_RESET;
  int                    frames_sent = 0;
  int                    settings = 1;
  int unsigned           cycles = 0;
  reg_write_t            reg_batch[$];

  fsp_item_if   item_ch ();
  fsp_result_if result_ch ();

  fixed_step_frame_pacer_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .item      (item_ch),
    .result    (result_ch)
  );

  fixed_step_frame_pacer_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .item_mon      (item_ch),
    .result_mon    (result_ch),
    .errors        (errors),
    .pending       (pending),
    .results_seen  (results_seen),
    .cfg_err_steps (cfg_err_steps),
    .phase_peak    (phase_peak)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // result side: after each taken result, drop ready for a random hold while idle is set
  initial begin : result_pacing
    int   hold;
    logic rdy;
    hold = 0;
    result_ch.ready <= 1'b1;
    forever begin
      @(posedge clk);
      rdy = result_ch.ready;
      if (result_ch.valid && result_ch.ready) begin
        hold = idle ? $urandom_range(0, 10) : 0;
        rdy = (hold == 0);
      end else if (result_ch.valid && !rdy) begin
        hold = (hold > 0) ? hold - 1 : 0;
        rdy = (hold == 0);
      end
      result_ch.ready <= rdy;
    end
  end

  // returns at the edge where the transaction is accepted
  task automatic send_frame(input logic k, input logic [TICK_W-1:0] tick, input logic req);
    int gap;
    gap = idle ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.valid         <= 1'b1;
    item_ch.kind          <= k;
    item_ch.now_tick      <= tick;
    item_ch.pause_request <= req;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    stamp = tick;
    frames_sent++;
  endtask

  task automatic settle();
    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic queue_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    reg_write_t w;
    w.idx = idx;
    w.data = data;
    reg_batch.push_back(w);
    if (idx == CFG_GAP_LIMIT) cur_max_el = data[ELAPSED_W-1:0];
  endtask

  task automatic flush_regs();
    foreach (reg_batch[i]) begin
      cfg_we    <= 1'b1;
      cfg_index <= reg_batch[i].idx;
      cfg_wdata <= reg_batch[i].data;
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    reg_batch.delete();
    settings++;
  endtask

  function automatic logic [TICK_W-1:0] pick_tick();
    int unsigned       sel;
    logic [TICK_W-1:0] span;
    sel = $urandom_range(0, 99);
    span = {1'b0, cur_max_el} + {4'd0, cur_max_el[ELAPSED_W-1:3]} + 1;
    if (sel < 60) return stamp + $urandom_range(0, span);
    if (sel < 75) return stamp + $urandom_range(0, 3);
    if (sel < 90) return $urandom;
    // backward stamp wraps into a huge elapsed count
    return stamp - $urandom_range(1, 1000);
  endfunction

  task automatic run_frames(input int n);
    logic k;
    for (int i = 0; i < n; i++) begin
      k = ($urandom_range(0, 99) < 12) ? KIND_ADVANCE_PAUSE : KIND_ADVANCE;
      send_frame(k, pick_tick(), 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic random_settings();
    logic [FREQ_W-1:0] lo;
    int unsigned       sel;
    lo = (phase_peak >= MIN_CLOCK_HZ_DEFAULT) ? phase_peak + 1 : MIN_CLOCK_HZ_DEFAULT;
    queue_reg(CFG_TICK_RATE, lo + $urandom_range(0, 40000));
    sel = $urandom_range(0, 99);
    if (sel < 70)      queue_reg(CFG_GAP_LIMIT, $urandom_range(1, 4000));
    else if (sel < 90) queue_reg(CFG_GAP_LIMIT, $urandom_range(1, 20));
    else               queue_reg(CFG_GAP_LIMIT, $urandom_range(1, 32'h7fff_ffff));
    queue_reg(CFG_SHOW_MODE, $urandom_range(0, 1));
    queue_reg(CFG_SIMULATION_RATE, $urandom_range(1, RATE_MAX));
    queue_reg(CFG_FRAME_RATE, $urandom_range(1, RATE_MAX));
    if ($urandom_range(0, 1)) queue_reg(CFG_STEP_CAP, $urandom_range(1, 255));
    else                      queue_reg(CFG_STEP_CAP, $urandom_range(1, 8));
    queue_reg(CFG_START_TICK, $urandom);
  endtask

  // one register pushed out of its legal range
  task automatic bad_setting(input int which);
    case (which)
      0: queue_reg(CFG_TICK_RATE, $urandom_range(0, MIN_CLOCK_HZ_DEFAULT - 1));
      1: queue_reg(CFG_GAP_LIMIT, '0);
      2: queue_reg(CFG_SIMULATION_RATE, '0);
      3: queue_reg(CFG_SIMULATION_RATE, $urandom_range(RATE_MAX + 1, 1023));
      4: queue_reg(CFG_FRAME_RATE, '0);
      5: queue_reg(CFG_FRAME_RATE, $urandom_range(RATE_MAX + 1, 1023));
      default: queue_reg(CFG_STEP_CAP, '0);
    endcase
  endtask

  initial begin
    rst                   <= 1'b1;
    cfg_we                <= 1'b0;
    cfg_index             <= '0;
    cfg_wdata             <= '0;
    item_ch.valid         <= 1'b0;
    item_ch.kind          <= KIND_ADVANCE;
    item_ch.now_tick      <= '0;
    item_ch.pause_request <= 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: boundaries of the elapsed clamp, wrap, catch-up, pause handling
    send_frame(KIND_ADVANCE, 32'd0, 1'b0);
    send_frame(KIND_ADVANCE, 32'd1, 1'b0);
    send_frame(KIND_ADVANCE, stamp + 250, 1'b0);
    send_frame(KIND_ADVANCE, stamp + 251, 1'b1);
    repeat (4) send_frame(KIND_ADVANCE, stamp + 250, 1'b0);
    send_frame(KIND_ADVANCE, 32'hffff_ffff, 1'b0);
    send_frame(KIND_ADVANCE, 32'd0, 1'b0);
    send_frame(KIND_ADVANCE_PAUSE, stamp + 100, 1'b1);
    send_frame(KIND_ADVANCE, stamp + 250, 1'b0);
    send_frame(KIND_ADVANCE, stamp + 250, 1'b1);
    send_frame(KIND_ADVANCE_PAUSE, stamp + 10, 1'b1);
    send_frame(KIND_ADVANCE_PAUSE, stamp + 50, 1'b0);
    send_frame(KIND_ADVANCE_PAUSE, stamp + 50, 1'b0);
    send_frame(KIND_ADVANCE, stamp, 1'b0);
    send_frame(KIND_ADVANCE, stamp - 1, 1'b0);
    send_frame(KIND_ADVANCE_PAUSE, stamp + 250, 1'b1);
    send_frame(KIND_ADVANCE_PAUSE, stamp + 250, 1'b0);
    send_frame(KIND_ADVANCE, stamp + 125, 1'b0);

    // top of every range but the tick rate, which sits at its minimum; legacy presentation
    settle();
    queue_reg(CFG_TICK_RATE, MIN_CLOCK_HZ_DEFAULT);
    queue_reg(CFG_GAP_LIMIT, 32'h7fff_ffff);
    queue_reg(CFG_SHOW_MODE, CFG_DATA_W'(MODE_LEGACY));
    queue_reg(CFG_SIMULATION_RATE, CFG_DATA_W'(RATE_MAX));
    queue_reg(CFG_FRAME_RATE, CFG_DATA_W'(RATE_MAX));
    queue_reg(CFG_STEP_CAP, 32'd255);
    queue_reg(CFG_START_TICK, $urandom);
    queue_reg(CFG_UNUSED, $urandom);
    flush_regs();
    run_frames(100);

    // bottom of every range
    settle();
    queue_reg(CFG_GAP_LIMIT, 32'd1);
    queue_reg(CFG_SHOW_MODE, CFG_DATA_W'(MODE_NORMAL));
    queue_reg(CFG_SIMULATION_RATE, 32'd1);
    queue_reg(CFG_FRAME_RATE, 32'd1);
    queue_reg(CFG_STEP_CAP, 32'd1);
    queue_reg(CFG_START_TICK, 32'hffff_ffff);
    flush_regs();
    run_frames(60);

    for (int s = 0; s < 12; s++) begin
      idle = (s % 4 != 3);
      settle();
      random_settings();
      flush_regs();
      run_frames(100);
      settle();
      bad_setting(s % 7);
      flush_regs();
      run_frames(5);
    end

    // widest frequency, then drop it under the phases to lock the error, then recover
    idle = 1'b1;
    settle();
    queue_reg(CFG_TICK_RATE, 32'hffff_ffff);
    queue_reg(CFG_GAP_LIMIT, $urandom_range(32'h0100_0000, 32'h7fff_ffff));
    queue_reg(CFG_SHOW_MODE, CFG_DATA_W'(MODE_NORMAL));
    queue_reg(CFG_SIMULATION_RATE, CFG_DATA_W'(RATE_MAX));
    queue_reg(CFG_FRAME_RATE, CFG_DATA_W'(RATE_MAX));
    queue_reg(CFG_STEP_CAP, $urandom_range(1, 255));
    flush_regs();
    run_frames(100);
    settle();
    queue_reg(CFG_TICK_RATE, MIN_CLOCK_HZ_DEFAULT);
    flush_regs();
    run_frames(10);
    settle();
    queue_reg(CFG_TICK_RATE, 32'hffff_ffff);
    flush_regs();
    run_frames(20);

    settle();
    repeat (100) @(posedge clk);
    $display("covered %0d frames over %0d register settings, %0d results compared",
             frames_sent, settings, results_seen);
    $display("%0d steps rejected for bad configuration or stale phase", cfg_err_steps);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- fixed_step_frame_pacer_core.f -----
rtl/core/fsp_pkg.sv
rtl/core/fsp_item_if.sv
rtl/core/fsp_result_if.sv
rtl/core/fsp_cfg.sv
rtl/core/fsp_div.sv
rtl/core/fixed_step_frame_pacer_core.sv
tb/sv/fixed_step_frame_pacer_checker.sv
tb/sv/fixed_step_frame_pacer_core_tb.sv
